// ===== hdl/ssp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types and constants for the sense data parser: beat layouts,
// byte positions inside a sense buffer and the response code values.
// ----------------------------------------------------------------------------
package ssp_pkg;

  // Bytes at or beyond this offset are ignored; the byte counter saturates.
  localparam int SENSE_LEN_BOUND = 32;
  localparam int IDX_W         = $clog2(SENSE_LEN_BOUND + 1);
  // Width for offset arithmetic in the descriptor walk (covers 255 + 1 + 255).
  localparam int POS_W         = 10;
  localparam int DESC_W        = 9;
  localparam logic [DESC_W-1:0] DESC_START_MAX = '1;

  // Response code values and masks.
  localparam logic [7:0] RSP_VALID_BITS = 8'h70;
  localparam logic [6:0] RSP_DESC_MIN   = 7'h72;
  localparam logic [7:0] RSP_DESC_CUR   = 8'h72;
  localparam logic [7:0] RSP_DESC_DEF   = 8'h73;
  localparam logic [7:0] WANTED_RESET   = 8'd9;

  // Byte positions inside a sense buffer.
  localparam int BYTE_CODE      = 0;
  localparam int BYTE_D_KEY     = 1;
  localparam int BYTE_D_ASC     = 2;
  localparam int BYTE_D_ASCQ    = 3;
  localparam int BYTE_F_KEY     = 2;
  localparam int BYTE_ADDLEN    = 7;
  localparam int BYTE_F_ASC     = 12;
  localparam int BYTE_F_ASCQ    = 13;
  localparam int DESC_AREA_BASE = 8;
  // Fixed format: byte 12 needs a length above 4, byte 13 above 5.
  localparam logic [7:0] F_ASC_MIN_LEN  = 8'd4;
  localparam logic [7:0] F_ASCQ_MIN_LEN = 8'd5;

  typedef struct packed {
    logic [7:0] sense_byte;
    logic       is_last;
  } sense_in_t;

  typedef struct packed {
    logic       sense_valid;
    logic [6:0] rsp_code;
    logic [3:0] key_nibble;
    logic [7:0] add_code;
    logic [7:0] add_qualifier;
    logic [7:0] add_length;
    logic       desc_found;
    logic [4:0] desc_offset;
  } sense_out_t;

endpackage

// ===== hdl/ssp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_core
// Per-buffer parse state and its combinational update for one sense byte,
// plus the summary that is formed from the updated state.
// ----------------------------------------------------------------------------
module ssp_core
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       step,
  input  sense_in_t  beat,
  output sense_out_t summary
);

  logic [7:0]        wanted_desc_type;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [7:0]        first_byte, first_byte_next;
  logic [3:0]        held_key, held_key_next;
  logic [7:0]        held_asc, held_asc_next;
  logic [7:0]        held_ascq, held_ascq_next;
  logic [7:0]        held_addlen, held_addlen_next;
  logic [DESC_W-1:0] next_desc_start, next_desc_start_next;
  logic              walk_found, walk_found_next;
  logic              walk_stop, walk_stop_next;
  logic              walk_len, walk_len_next;
  logic [4:0]        found_at, found_at_next;

  logic              active;
  logic              desc_fmt;
  logic              walk_on;
  logic              fb_valid;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  area_end;
  logic [POS_W-1:0]  nx;

  always_comb begin
    active   = byte_index < IDX_W'(SENSE_LEN_BOUND);
    desc_fmt = first_byte[6:0] >= RSP_DESC_MIN;
    walk_on  = (first_byte == RSP_DESC_CUR) || (first_byte == RSP_DESC_DEF);
    pos      = POS_W'(byte_index);
    area_end = POS_W'(DESC_AREA_BASE) + POS_W'(held_addlen);
    nx       = pos + POS_W'(1) + POS_W'(beat.sense_byte);

    byte_index_next      = byte_index;
    first_byte_next      = first_byte;
    held_key_next        = held_key;
    held_asc_next        = held_asc;
    held_ascq_next       = held_ascq;
    held_addlen_next     = held_addlen;
    next_desc_start_next = next_desc_start;
    walk_found_next      = walk_found;
    walk_stop_next       = walk_stop;
    walk_len_next        = walk_len;
    found_at_next        = found_at;

    if (active) begin
      byte_index_next = byte_index + IDX_W'(1);
      if (byte_index == IDX_W'(BYTE_CODE)) begin
        first_byte_next = beat.sense_byte;
      end else if (desc_fmt) begin
        if (byte_index == IDX_W'(BYTE_D_KEY)) held_key_next = beat.sense_byte[3:0];
        if (byte_index == IDX_W'(BYTE_D_ASC)) held_asc_next = beat.sense_byte;
        if (byte_index == IDX_W'(BYTE_D_ASCQ)) held_ascq_next = beat.sense_byte;
      end else begin
        if (byte_index == IDX_W'(BYTE_F_KEY)) held_key_next = beat.sense_byte[3:0];
        if (byte_index == IDX_W'(BYTE_F_ASC) && held_addlen > F_ASC_MIN_LEN)
          held_asc_next = beat.sense_byte;
        if (byte_index == IDX_W'(BYTE_F_ASCQ) && held_addlen > F_ASCQ_MIN_LEN)
          held_ascq_next = beat.sense_byte;
      end
      if (byte_index == IDX_W'(BYTE_ADDLEN)) held_addlen_next = beat.sense_byte;

      // Descriptor walk: type byte at next_desc_start, length byte after it.
      if (walk_on && pos >= POS_W'(DESC_AREA_BASE) && !walk_found && !walk_stop) begin
        if (!walk_len) begin
          if (pos == POS_W'(next_desc_start)) begin
            if (pos >= area_end) begin
              walk_stop_next = 1'b1;
            end else if (beat.sense_byte == wanted_desc_type) begin
              walk_found_next = 1'b1;
              found_at_next   = pos[4:0];
            end else if (pos + POS_W'(1) >= area_end) begin
              walk_stop_next = 1'b1;
            end else begin
              walk_len_next = 1'b1;
            end
          end
        end else if (pos == POS_W'(next_desc_start) + POS_W'(1)) begin
          next_desc_start_next = (nx > POS_W'(DESC_START_MAX)) ? DESC_START_MAX
                                                               : nx[DESC_W-1:0];
          walk_len_next = 1'b0;
        end
      end
    end
  end

  // Summary from the state as it stands after this byte.
  always_comb begin
    fb_valid = (first_byte_next & RSP_VALID_BITS) == RSP_VALID_BITS;
    summary.sense_valid   = fb_valid;
    summary.rsp_code      = fb_valid ? first_byte_next[6:0] : 7'd0;
    summary.key_nibble    = fb_valid ? held_key_next : 4'd0;
    summary.add_code      = fb_valid ? held_asc_next : 8'd0;
    summary.add_qualifier = fb_valid ? held_ascq_next : 8'd0;
    summary.add_length    = (fb_valid && first_byte_next[6:0] >= RSP_DESC_MIN)
                            ? held_addlen_next : 8'd0;
    summary.desc_found    = walk_found_next;
    summary.desc_offset   = walk_found_next ? found_at_next : 5'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wanted_desc_type <= WANTED_RESET;
    end else if (cfg_wr_en) begin
      wanted_desc_type <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.is_last)) begin
      byte_index      <= '0;
      first_byte      <= '0;
      held_key        <= '0;
      held_asc        <= '0;
      held_ascq       <= '0;
      held_addlen     <= '0;
      next_desc_start <= DESC_W'(DESC_AREA_BASE);
      walk_found      <= 1'b0;
      walk_stop       <= 1'b0;
      walk_len        <= 1'b0;
      found_at        <= '0;
    end else if (step) begin
      byte_index      <= byte_index_next;
      first_byte      <= first_byte_next;
      held_key        <= held_key_next;
      held_asc        <= held_asc_next;
      held_ascq       <= held_ascq_next;
      held_addlen     <= held_addlen_next;
      next_desc_start <= next_desc_start_next;
      walk_found      <= walk_found_next;
      walk_stop       <= walk_stop_next;
      walk_len        <= walk_len_next;
      found_at        <= found_at_next;
    end
  end

endmodule

// ===== hdl/scsi_sense_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scsi_sense_parser
// Streams a sense buffer one byte per beat and emits one summary beat on the
// byte marked last: response code, key, ASC/ASCQ, length, descriptor search.
// ----------------------------------------------------------------------------
// A summary passes the input register, then the result register, after its
// last byte is accepted.
// Throughput: one byte per cycle unless a last byte waits on a full, stalled
// result register; the byte update is combinational, input reg to state regs.
// Reset (rst, synchronous, active high) clears the parse state, empties both
// registers and sets the wanted descriptor type to 9.
// ----------------------------------------------------------------------------
module scsi_sense_parser
  import ssp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  sense_in_t  in_beat,
  output logic       out_valid,
  input  logic       out_stall,
  output sense_out_t out_beat
);

  // Input register: holds one beat until the parse stage takes it.
  logic       hold_valid, hold_valid_next;
  sense_in_t  hold_beat;
  logic       in_take;
  // A byte moves into the parse state when it is present and, if it closes a
  // buffer, the result register is free or is being emptied this cycle.
  logic       advance;
  logic       emit;
  logic       out_valid_next;
  sense_out_t summary;

  always_comb begin
    advance  = hold_valid && (!hold_beat.is_last || !out_valid || !out_stall);
    emit     = advance && hold_beat.is_last;
    in_stall = hold_valid && !advance;
    in_take  = in_valid && !in_stall;

    hold_valid_next = hold_valid;
    if (in_take) begin
      hold_valid_next = 1'b1;
    end else if (advance) begin
      hold_valid_next = 1'b0;
    end

    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_beat <= in_beat;
    end
    if (emit) begin
      out_beat <= summary;
    end
  end

  ssp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (advance),
    .beat        (hold_beat),
    .summary     (summary)
  );

  // A last byte that cannot move on must stay in the input register.
  a_last_held: assert property (@(posedge clk) disable iff (rst)
    hold_valid && hold_beat.is_last && out_valid && out_stall |=> hold_valid)
    else $error("last byte dropped while result register was full");

  // A closing byte that advances always produces a result beat.
  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("summary not presented after last byte");

  // A found descriptor only comes from descriptor-format sense 0x72 or 0x73.
  a_found_fmt: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.desc_found |->
      out_beat.sense_valid &&
      (out_beat.rsp_code == RSP_DESC_CUR[6:0] ||
       out_beat.rsp_code == RSP_DESC_DEF[6:0]))
    else $error("descriptor found outside descriptor-format sense");

  // Invalid sense reports all-zero decode fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_beat.sense_valid |->
      out_beat.rsp_code == 7'd0 && out_beat.key_nibble == 4'd0 &&
      out_beat.add_code == 8'd0 && out_beat.add_qualifier == 8'd0 &&
      out_beat.add_length == 8'd0)
    else $error("invalid sense carries nonzero fields");

endmodule
